@@ rtl/core/seg_isect_pkg.sv @@
// package for the segment intersection test
// holds register indexes, outcome codes and port field widths; no dependencies

package seg_isect_pkg;

    // configuration port
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 16;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_DET_TOLERANCE   = 2'd0,
        REG_PARAM_TOLERANCE = 2'd1
    } cfg_reg_t;

    localparam logic [CFG_DATA_WIDTH-1:0] DET_TOLERANCE_RESET   = 16'd3;
    localparam logic [CFG_DATA_WIDTH-1:0] PARAM_TOLERANCE_RESET = 16'd655;

    // parameter tolerance is a Q0.16 fraction
    localparam int PARAM_FRAC_BITS = 16;

    // result codes, first failing check
    typedef enum logic [1:0] {
        OUTCOME_HIT      = 2'd0,
        OUTCOME_PARALLEL = 2'd1,
        OUTCOME_T1_OUT   = 2'd2,
        OUTCOME_T2_OUT   = 2'd3
    } outcome_t;

    // result tdata: hit, outcome, zero fill to one byte
    localparam int OUT_TDATA_WIDTH = 8;

endpackage

@@ rtl/core/segment_intersection_test.sv @@
// segment intersection test with tolerance, six-stage pipeline
// depends on seg_isect_pkg for register indexes and outcome codes
//
// usage:
//   s_ channel: one segment pair per transfer, eight signed coordinates
//     of COORD_WIDTH bits each in s_tdata.
//   m_ channel: one result per pair, hit flag and 2-bit outcome code
//     (hit, nearly parallel, first parameter out, second parameter out).
//   cfg channel: write det_tolerance (index 0) or param_tolerance
//     (index 1); cfg_ready is always high, other indexes are ignored.
//     write only while no pair is in flight.
// pipeline: six register stages (differences, products, determinant and
//   numerators, sign fold, tolerance multiply, range compare), the first
//   loaded by the transfer; m_tvalid rises once the last holds the pair.
// throughput: one pair per cycle while m_tready is high, set by the per-stage valid/ready chain.
// stall: when m_tready is low the result holds in the output register;
//   stages behind it still fill empty slots, so s_tready drops only once
//   every stage holds a pair. nothing is lost or repeated.
// reset: aresetn low empties all stages and loads the register defaults
//   (det_tolerance 3, param_tolerance 655).

module segment_intersection_test #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    // fields from bit 0 up: seg1_start_x, seg1_start_y, seg1_end_x,
    // seg1_end_y, seg2_start_x, seg2_start_y, seg2_end_x, seg2_end_y
    input  logic [8*COORD_WIDTH-1:0]                    s_tdata,
    input  logic                                        s_tvalid,
    output logic                                        s_tready,
    // fields from bit 0 up: hit (1), outcome (2), zero fill
    output logic [seg_isect_pkg::OUT_TDATA_WIDTH-1:0]   m_tdata,
    output logic                                        m_tvalid,
    input  logic                                        m_tready,
    input  logic                                        cfg_valid,
    output logic                                        cfg_ready,
    input  logic [seg_isect_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic [seg_isect_pkg::CFG_DATA_WIDTH-1:0]    cfg_data
);

    import seg_isect_pkg::*;

    localparam int DW     = COORD_WIDTH + 1;          // coordinate differences
    localparam int PW     = 2 * COORD_WIDTH + 2;      // single products
    localparam int NW     = 2 * COORD_WIDTH + 3;      // determinant, numerators
    localparam int AW     = 2 * COORD_WIDTH + 2;      // |d|
    localparam int SW     = AW + CFG_DATA_WIDTH;      // |d| * param_tolerance
    localparam int CW     = 2 * COORD_WIDTH + 20;     // range compare sums
    localparam int STAGES = 6;

    // configuration registers
    logic [CFG_DATA_WIDTH-1:0] det_tol_reg;
    logic [CFG_DATA_WIDTH-1:0] param_tol_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            det_tol_reg   <= DET_TOLERANCE_RESET;
            param_tol_reg <= PARAM_TOLERANCE_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == REG_DET_TOLERANCE) begin
                det_tol_reg <= cfg_data;
            end
            if (cfg_index == REG_PARAM_TOLERANCE) begin
                param_tol_reg <= cfg_data;
            end
        end
    end

    // stage valid bits and ready chain, a stage loads when empty or draining
    logic [STAGES-1:0] valid_reg;
    logic [STAGES:0]   stage_ready;

    always_comb begin
        stage_ready[STAGES] = m_tready;
        for (int k = STAGES - 1; k >= 0; k--) begin
            stage_ready[k] = !valid_reg[k] || stage_ready[k+1];
        end
    end

    assign s_tready = stage_ready[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (stage_ready[0]) begin
                valid_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < STAGES; k++) begin
                if (stage_ready[k]) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // input coordinates
    logic signed [COORD_WIDTH-1:0] s1x, s1y, e1x, e1y, s2x, s2y, e2x, e2y;

    assign s1x = s_tdata[0*COORD_WIDTH +: COORD_WIDTH];
    assign s1y = s_tdata[1*COORD_WIDTH +: COORD_WIDTH];
    assign e1x = s_tdata[2*COORD_WIDTH +: COORD_WIDTH];
    assign e1y = s_tdata[3*COORD_WIDTH +: COORD_WIDTH];
    assign s2x = s_tdata[4*COORD_WIDTH +: COORD_WIDTH];
    assign s2y = s_tdata[5*COORD_WIDTH +: COORD_WIDTH];
    assign e2x = s_tdata[6*COORD_WIDTH +: COORD_WIDTH];
    assign e2y = s_tdata[7*COORD_WIDTH +: COORD_WIDTH];

    // stage 1: direction vectors and start offset
    logic signed [DW-1:0] v1x_reg, v1y_reg, v2x_reg, v2y_reg, dx_reg, dy_reg;

    always_ff @(posedge aclk) begin
        if (stage_ready[0]) begin
            v1x_reg <= DW'(e1x) - DW'(s1x);
            v1y_reg <= DW'(e1y) - DW'(s1y);
            v2x_reg <= DW'(s2x) - DW'(e2x);
            v2y_reg <= DW'(s2y) - DW'(e2y);
            dx_reg  <= DW'(s2x) - DW'(s1x);
            dy_reg  <= DW'(s2y) - DW'(s1y);
        end
    end

    // stage 2: the six cross products
    logic signed [PW-1:0] pd_a_reg, pd_b_reg, pn1_a_reg, pn1_b_reg, pn2_a_reg, pn2_b_reg;

    always_ff @(posedge aclk) begin
        if (stage_ready[1]) begin
            pd_a_reg  <= PW'(v1x_reg) * PW'(v2y_reg);
            pd_b_reg  <= PW'(v1y_reg) * PW'(v2x_reg);
            pn1_a_reg <= PW'(dx_reg) * PW'(v2y_reg);
            pn1_b_reg <= PW'(v2x_reg) * PW'(dy_reg);
            pn2_a_reg <= PW'(v1x_reg) * PW'(dy_reg);
            pn2_b_reg <= PW'(v1y_reg) * PW'(dx_reg);
        end
    end

    // stage 3: determinant and the two numerators
    logic signed [NW-1:0] d_reg, n1_reg, n2_reg;

    always_ff @(posedge aclk) begin
        if (stage_ready[2]) begin
            d_reg  <= NW'(pd_a_reg) - NW'(pd_b_reg);
            n1_reg <= NW'(pn1_a_reg) - NW'(pn1_b_reg);
            n2_reg <= NW'(pn2_a_reg) - NW'(pn2_b_reg);
        end
    end

    // stage 4: fold the sign of d into the numerators
    logic [AW-1:0]        ad_reg;
    logic signed [NW-1:0] m1_reg, m2_reg;
    logic signed [NW-1:0] d_abs;

    assign d_abs = d_reg[NW-1] ? -d_reg : d_reg;

    always_ff @(posedge aclk) begin
        if (stage_ready[3]) begin
            ad_reg <= AW'(d_abs);
            m1_reg <= d_reg[NW-1] ? -n1_reg : n1_reg;
            m2_reg <= d_reg[NW-1] ? -n2_reg : n2_reg;
        end
    end

    // stage 5: tolerance slack and the parallel check
    logic [SW-1:0]        slack_reg;
    logic [AW-1:0]        ad5_reg;
    logic signed [NW-1:0] m1_5_reg, m2_5_reg;
    logic                 parallel_reg;

    always_ff @(posedge aclk) begin
        if (stage_ready[4]) begin
            slack_reg    <= SW'(ad_reg) * SW'(param_tol_reg);
            ad5_reg      <= ad_reg;
            m1_5_reg     <= m1_reg;
            m2_5_reg     <= m2_reg;
            parallel_reg <= (ad_reg == '0) || (ad_reg < AW'(det_tol_reg));
        end
    end

    // stage 6: range compares against -tol*|d| and (1+tol)*|d|
    logic signed [CW-1:0] slack_x, ad16_x, ms1_x, ms2_x;
    logic signed [CW-1:0] lo1, hi1, lo2, hi2;
    logic                 t1_in, t2_in;
    outcome_t             code;

    assign slack_x = $signed(CW'(slack_reg));
    assign ad16_x  = $signed(CW'({ad5_reg, {PARAM_FRAC_BITS{1'b0}}}));
    assign ms1_x   = CW'(m1_5_reg) <<< PARAM_FRAC_BITS;
    assign ms2_x   = CW'(m2_5_reg) <<< PARAM_FRAC_BITS;
    assign lo1     = ms1_x + slack_x;
    assign hi1     = ad16_x + slack_x - ms1_x;
    assign lo2     = ms2_x + slack_x;
    assign hi2     = ad16_x + slack_x - ms2_x;
    assign t1_in   = !lo1[CW-1] && !hi1[CW-1];
    assign t2_in   = !lo2[CW-1] && !hi2[CW-1];

    always_comb begin
        priority if (parallel_reg) begin
            code = OUTCOME_PARALLEL;
        end else if (!t1_in) begin
            code = OUTCOME_T1_OUT;
        end else if (!t2_in) begin
            code = OUTCOME_T2_OUT;
        end else begin
            code = OUTCOME_HIT;
        end
    end

    // output register
    logic     hit_reg;
    outcome_t outcome_reg;

    always_ff @(posedge aclk) begin
        if (stage_ready[5]) begin
            hit_reg     <= (code == OUTCOME_HIT);
            outcome_reg <= code;
        end
    end

    assign m_tvalid = valid_reg[STAGES-1];
    assign m_tdata  = {{(OUT_TDATA_WIDTH - 3){1'b0}}, outcome_reg, hit_reg};

endmodule
